FILE: hw/rtl/fsp_pkg.sv
package fsp_pkg;

  // Sequence limits and phase accumulator format
  localparam int unsigned MaxFrames = 65536;
  localparam int unsigned FracBits  = 16;

  // Field widths
  localparam int unsigned ActionW = 2;
  localparam int unsigned DeltaW  = 16;
  localparam int unsigned FrameW  = 16;
  localparam int unsigned RateW   = 8;
  localparam int unsigned TotalW  = 17;
  localparam int unsigned EndW    = 17;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgW    = 17;

  // Delta times rate, Q8.16
  localparam int unsigned ProdW  = DeltaW + RateW;
  // Rescale of the product onto the phase fraction
  localparam int unsigned ShiftL = (FracBits >= 16) ? FracBits - 16 : 0;
  localparam int unsigned ShiftR = (FracBits >= 16) ? 0 : 16 - FracBits;
  localparam int unsigned ExtW   = ProdW + ShiftL;
  localparam int unsigned ScaleW = FracBits + RateW;
  localparam int unsigned AccW   = FracBits + RateW + 1;
  localparam int unsigned AdvW   = AccW - FracBits;
  // Wrap arithmetic spans one bit beyond the 16-bit frame width
  localparam int unsigned SpanW  = FrameW + 1;
  localparam int unsigned CntW   = $clog2(SpanW);

  localparam logic [TotalW-1:0] TotalCap =
      (MaxFrames < 65536) ? TotalW'(MaxFrames) : TotalW'(65536);

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgFrameRate   = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] CfgTotalFrames = CfgIdxW'(1);
  localparam logic [CfgIdxW-1:0] CfgStartFrame  = CfgIdxW'(2);
  localparam logic [CfgIdxW-1:0] CfgEndFrame    = CfgIdxW'(3);
  localparam logic [CfgIdxW-1:0] CfgLooping     = CfgIdxW'(4);

  typedef enum logic [ActionW-1:0] {
    ACT_TICK    = 2'd0,
    ACT_SCRUB   = 2'd1,
    ACT_PLAY    = 2'd2,
    ACT_RESTART = 2'd3
  } fsp_action_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_MUL,
    ST_ACC,
    ST_WIN,
    ST_MOD,
    ST_DONE
  } fsp_state_e;

endpackage

FILE: hw/rtl/fsp_in_if.sv
interface fsp_in_if;
  logic                          valid;
  logic                          ready;
  logic [fsp_pkg::ActionW-1:0]   action;
  logic [fsp_pkg::DeltaW-1:0]    elapsed;
  logic [fsp_pkg::FrameW-1:0]    requested_frame;
  logic                          play_value;

  modport source (output valid, action, elapsed, requested_frame, play_value,
                  input ready);
  modport sink   (input valid, action, elapsed, requested_frame, play_value,
                  output ready);
endinterface

FILE: hw/rtl/fsp_out_if.sv
interface fsp_out_if;
  logic                        valid;
  logic                        ready;
  logic [fsp_pkg::FrameW-1:0]  frame_index;
  logic                        is_playing;
  logic                        frame_changed;

  modport source (output valid, frame_index, is_playing, frame_changed,
                  input ready);
  modport sink   (input valid, frame_index, is_playing, frame_changed,
                  output ready);
endinterface

FILE: hw/rtl/frame_sequence_playback_top.sv
// Channel | dir | transfer when   | payload
// --------+-----+-----------------+---------------------------------------------
// in_i    | in  | valid && ready  | action, elapsed, requested_frame, play_value
// out_o   | out | valid && ready  | frame_index, is_playing, frame_changed
// cfg     | in  | cfg_we_i        | cfg_idx_i selects register, cfg_data_i value
//
// Steps: play, scrub and restart, and a tick while stopped, go through an
// execute step to the result. A playing tick runs an 8-step shift-add multiply,
// then an accumulate step and, if the frame advances, a window step; a looping
// wrap adds a 17-step restoring remainder.
// Reset: state cleared, registers to their defaults (rate 30, one frame,
// window whole sequence, looping on). Stalls: a finished result waits in the
// output register; the next item is taken meanwhile and holds in its last step.
module frame_sequence_playback_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [fsp_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [fsp_pkg::CfgW-1:0]      cfg_data_i,
  fsp_in_if.sink                        in_i,
  fsp_out_if.source                     out_o
);

  // Configuration registers
  logic [fsp_pkg::RateW-1:0]  frame_rate_q;
  logic [fsp_pkg::TotalW-1:0] total_frames_q;
  logic [fsp_pkg::FrameW-1:0] start_frame_q;
  logic [fsp_pkg::EndW-1:0]   end_frame_q;
  logic                       looping_q;

  // Playback state
  logic [fsp_pkg::FrameW-1:0]   cur_q, cur_d;
  logic [fsp_pkg::FracBits-1:0] phase_q, phase_d;
  logic                         playing_q, playing_d;

  // Sequencer and held item
  fsp_pkg::fsp_state_e        state_q, state_d;
  fsp_pkg::fsp_action_e       action_q;
  logic [fsp_pkg::DeltaW-1:0] delta_q;
  logic [fsp_pkg::FrameW-1:0] req_q;
  logic                       pv_q;

  // Shared datapath registers
  logic [fsp_pkg::CntW-1:0]   cnt_q, cnt_d;
  logic [fsp_pkg::ProdW-1:0]  prod_q, prod_d;
  logic [fsp_pkg::AdvW-1:0]   adv_q, adv_d;
  logic [fsp_pkg::SpanW-1:0]  num_q, num_d;
  logic [fsp_pkg::SpanW-1:0]  len_q, len_d;
  logic [fsp_pkg::SpanW-1:0]  rem_q, rem_d;
  logic                       changed_q, changed_d;

  // Output register
  logic                       out_valid_q, out_valid_d;
  logic [fsp_pkg::FrameW-1:0] out_frame_q;
  logic                       out_play_q;
  logic                       out_chg_q;
  logic                       out_load;

  logic in_xfer;
  assign in_xfer = in_i.valid && in_i.ready;
  assign in_i.ready = (state_q == fsp_pkg::ST_IDLE);

  // ---------------------------------------------------------------------------
  // Window: clamp total to 1..cap, start to last, end into start..last
  // ---------------------------------------------------------------------------
  logic [fsp_pkg::TotalW-1:0] eff_total;
  logic [fsp_pkg::FrameW-1:0] last_frame, win_s, win_e, end_lo;

  always_comb begin
    eff_total = total_frames_q;
    if (total_frames_q == '0) begin
      eff_total = fsp_pkg::TotalW'(1);
    end else if (total_frames_q > fsp_pkg::TotalCap) begin
      eff_total = fsp_pkg::TotalCap;
    end
    last_frame = fsp_pkg::FrameW'(eff_total - fsp_pkg::TotalW'(1));
    win_s = (start_frame_q > last_frame) ? last_frame : start_frame_q;
    end_lo = end_frame_q[fsp_pkg::FrameW-1:0];
    if (end_frame_q[fsp_pkg::EndW-1]) begin
      win_e = last_frame;
    end else if (end_lo < win_s) begin
      win_e = win_s;
    end else if (end_lo > last_frame) begin
      win_e = last_frame;
    end else begin
      win_e = end_lo;
    end
  end

  // ---------------------------------------------------------------------------
  // Shared arithmetic
  // ---------------------------------------------------------------------------
  // Multiply step: MSB-first shift-add of delta by one rate bit
  logic [fsp_pkg::RateW-1:0] rate_bit_sel;
  logic                      rate_bit;
  logic [fsp_pkg::ProdW-1:0] mul_next;
  assign rate_bit_sel = frame_rate_q >> (fsp_pkg::RateW - 1 - fsp_pkg::RateW'(cnt_q));
  assign rate_bit = rate_bit_sel[0];
  assign mul_next = {prod_q[fsp_pkg::ProdW-2:0], 1'b0}
                  + (rate_bit ? fsp_pkg::ProdW'(delta_q) : '0);

  // Phase accumulate
  logic [fsp_pkg::ExtW-1:0]   p_ext;
  logic [fsp_pkg::ScaleW-1:0] p_scaled;
  logic [fsp_pkg::AccW-1:0]   acc;
  assign p_ext    = fsp_pkg::ExtW'(prod_q) << fsp_pkg::ShiftL;
  assign p_scaled = fsp_pkg::ScaleW'(p_ext >> fsp_pkg::ShiftR);
  assign acc      = fsp_pkg::AccW'(phase_q) + fsp_pkg::AccW'(p_scaled);

  // Window advance
  logic [fsp_pkg::FrameW-1:0] cur_snap;
  logic [fsp_pkg::SpanW-1:0]  next_frame;
  assign cur_snap   = (cur_q < win_s || cur_q > win_e) ? win_s : cur_q;
  assign next_frame = fsp_pkg::SpanW'(cur_snap) + fsp_pkg::SpanW'(adv_q);

  // Remainder step: one restoring subtract per cycle
  logic [fsp_pkg::SpanW-1:0] trial, rem_step;
  assign trial    = {rem_q[fsp_pkg::SpanW-2:0], num_q[fsp_pkg::SpanW-1]};
  assign rem_step = (trial >= len_q) ? trial - len_q : trial;

  // Scrub clamp
  logic [fsp_pkg::FrameW-1:0] scrub_frame;
  assign scrub_frame = (req_q < win_s) ? win_s : ((req_q > win_e) ? win_e : req_q);

  assign out_load = (state_q == fsp_pkg::ST_DONE) && (!out_valid_q || out_o.ready);

  // ---------------------------------------------------------------------------
  // Next state
  // ---------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      fsp_pkg::ST_IDLE: begin
        if (in_xfer) state_d = fsp_pkg::ST_EXEC;
      end
      fsp_pkg::ST_EXEC: begin
        if (action_q == fsp_pkg::ACT_TICK && playing_q) begin
          state_d = fsp_pkg::ST_MUL;
        end else begin
          state_d = fsp_pkg::ST_DONE;
        end
      end
      fsp_pkg::ST_MUL: begin
        if (cnt_q == fsp_pkg::CntW'(fsp_pkg::RateW - 1)) state_d = fsp_pkg::ST_ACC;
      end
      fsp_pkg::ST_ACC: begin
        state_d = (acc[fsp_pkg::AccW-1:fsp_pkg::FracBits] == '0) ? fsp_pkg::ST_DONE
                                                                 : fsp_pkg::ST_WIN;
      end
      fsp_pkg::ST_WIN: begin
        if ((looping_q || cur_q < win_e) && next_frame > fsp_pkg::SpanW'(win_e)
            && looping_q) begin
          state_d = fsp_pkg::ST_MOD;
        end else begin
          state_d = fsp_pkg::ST_DONE;
        end
      end
      fsp_pkg::ST_MOD: begin
        if (cnt_q == fsp_pkg::CntW'(fsp_pkg::SpanW - 1)) state_d = fsp_pkg::ST_DONE;
      end
      fsp_pkg::ST_DONE: begin
        if (out_load) state_d = fsp_pkg::ST_IDLE;
      end
      default: state_d = fsp_pkg::ST_IDLE;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Datapath updates
  // ---------------------------------------------------------------------------
  always_comb begin
    cur_d       = cur_q;
    phase_d     = phase_q;
    playing_d   = playing_q;
    cnt_d       = cnt_q;
    prod_d      = prod_q;
    adv_d       = adv_q;
    num_d       = num_q;
    len_d       = len_q;
    rem_d       = rem_q;
    changed_d   = changed_q;
    out_valid_d = out_valid_q;
    if (out_o.ready) out_valid_d = 1'b0;
    if (out_load) out_valid_d = 1'b1;

    unique case (state_q)
      fsp_pkg::ST_IDLE: begin
        changed_d = 1'b0;
        cnt_d     = '0;
        prod_d    = '0;
      end
      fsp_pkg::ST_EXEC: begin
        unique case (action_q)
          fsp_pkg::ACT_TICK: ;
          fsp_pkg::ACT_SCRUB: begin
            cur_d     = scrub_frame;
            changed_d = 1'b1;
          end
          fsp_pkg::ACT_PLAY: begin
            playing_d = pv_q;
          end
          fsp_pkg::ACT_RESTART: begin
            cur_d     = '0;
            phase_d   = '0;
            changed_d = 1'b1;
          end
          default: ;
        endcase
      end
      fsp_pkg::ST_MUL: begin
        prod_d = mul_next;
        cnt_d  = cnt_q + fsp_pkg::CntW'(1);
      end
      fsp_pkg::ST_ACC: begin
        phase_d = acc[fsp_pkg::FracBits-1:0];
        adv_d   = acc[fsp_pkg::AccW-1:fsp_pkg::FracBits];
      end
      fsp_pkg::ST_WIN: begin
        cnt_d = '0;
        rem_d = '0;
        if (!looping_q && cur_q >= win_e) begin
          // One-shot already at the end: stop, frame stays
          playing_d = 1'b0;
        end else if (next_frame > fsp_pkg::SpanW'(win_e)) begin
          if (looping_q) begin
            num_d = next_frame - fsp_pkg::SpanW'(win_s);
            len_d = fsp_pkg::SpanW'(win_e) - fsp_pkg::SpanW'(win_s) + fsp_pkg::SpanW'(1);
          end else begin
            cur_d     = win_e;
            playing_d = 1'b0;
            changed_d = (win_e != cur_q);
          end
        end else begin
          cur_d     = next_frame[fsp_pkg::FrameW-1:0];
          changed_d = (next_frame[fsp_pkg::FrameW-1:0] != cur_q);
        end
      end
      fsp_pkg::ST_MOD: begin
        rem_d = rem_step;
        num_d = {num_q[fsp_pkg::SpanW-2:0], 1'b0};
        cnt_d = cnt_q + fsp_pkg::CntW'(1);
        if (cnt_q == fsp_pkg::CntW'(fsp_pkg::SpanW - 1)) begin
          cur_d     = win_s + rem_step[fsp_pkg::FrameW-1:0];
          changed_d = ((win_s + rem_step[fsp_pkg::FrameW-1:0]) != cur_q);
        end
      end
      fsp_pkg::ST_DONE: ;
      default: ;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_rate_q   <= fsp_pkg::RateW'(30);
      total_frames_q <= fsp_pkg::TotalW'(1);
      start_frame_q  <= '0;
      end_frame_q    <= '1;
      looping_q      <= 1'b1;
    end else if (cfg_we_i) begin
      // Drop writes to unknown indexes
      unique case (cfg_idx_i)
        fsp_pkg::CfgFrameRate:   frame_rate_q   <= cfg_data_i[fsp_pkg::RateW-1:0];
        fsp_pkg::CfgTotalFrames: total_frames_q <= cfg_data_i[fsp_pkg::TotalW-1:0];
        fsp_pkg::CfgStartFrame:  start_frame_q  <= cfg_data_i[fsp_pkg::FrameW-1:0];
        fsp_pkg::CfgEndFrame:    end_frame_q    <= cfg_data_i[fsp_pkg::EndW-1:0];
        fsp_pkg::CfgLooping:     looping_q      <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= fsp_pkg::ST_IDLE;
      cur_q       <= '0;
      phase_q     <= '0;
      playing_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cur_q       <= cur_d;
      phase_q     <= phase_d;
      playing_q   <= playing_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload and work registers: no reset
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      action_q <= fsp_pkg::fsp_action_e'(in_i.action);
      delta_q  <= in_i.elapsed;
      req_q    <= in_i.requested_frame;
      pv_q     <= in_i.play_value;
    end
    cnt_q     <= cnt_d;
    prod_q    <= prod_d;
    adv_q     <= adv_d;
    num_q     <= num_d;
    len_q     <= len_d;
    rem_q     <= rem_d;
    changed_q <= changed_d;
    if (out_load) begin
      out_frame_q <= cur_q;
      out_play_q  <= playing_q;
      out_chg_q   <= changed_q;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.frame_index   = out_frame_q;
  assign out_o.is_playing    = out_play_q;
  assign out_o.frame_changed = out_chg_q;

endmodule

FILE: tb/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import fsp_pkg::*;

  // Quiet cycles tolerated before giving up: far more than one slow tick with a
  // wrap plus the random idle gaps on each side.
  localparam int unsigned IdleLimit    = 4000;
  // Drain time after the last result, a little above the slowest item
  localparam int unsigned SettleCycles = 40;
  localparam int unsigned NumPhases    = 14;
  localparam int unsigned PhaseItems   = 125;
  localparam int unsigned ScriptRows   = 38;
  // First register index past the end of the list; writes there are ignored
  localparam logic [CfgIdxW-1:0] CfgNone = CfgLooping + CfgIdxW'(1);

  typedef struct packed {
    logic [FrameW-1:0] frame;
    logic              playing;
    logic              changed;
  } playback_result_t;

  // One row of the directed script: either a register write or an item.
  // Rows with typed set carry their result; the rest go through the predictor.
  typedef struct packed {
    logic                is_cfg;
    logic [CfgIdxW-1:0]  reg_idx;
    logic [CfgW-1:0]     reg_data;
    fsp_action_e         act;
    logic [DeltaW-1:0]   delta;
    logic [FrameW-1:0]   req;
    logic                pv;
    logic                typed;
    playback_result_t    known;
  } script_row_t;

  script_row_t script [ScriptRows] = '{
    // Reset settings: one frame, rate 30, looping. Tick while stopped does nothing.
    '{1'b0, '0, '0, ACT_TICK,    16'hFFFF, 16'h0000, 1'b0, 1'b1, '{16'd0, 1'b0, 1'b0}},
    '{1'b0, '0, '0, ACT_PLAY,    16'h0000, 16'h0000, 1'b1, 1'b1, '{16'd0, 1'b1, 1'b0}},
    // Single-frame window: the advance wraps back onto the same frame
    '{1'b0, '0, '0, ACT_TICK,    16'hFFFF, 16'h0000, 1'b0, 1'b1, '{16'd0, 1'b1, 1'b0}},
    '{1'b0, '0, '0, ACT_SCRUB,   16'h0000, 16'hFFFF, 1'b0, 1'b1, '{16'd0, 1'b1, 1'b1}},
    '{1'b0, '0, '0, ACT_RESTART, 16'h0000, 16'h0000, 1'b0, 1'b1, '{16'd0, 1'b1, 1'b1}},
    // Full 65536-frame sequence at the top rate
    '{1'b1, CfgTotalFrames, 17'd65536,  ACT_TICK, '0, '0, 1'b0, 1'b0, '0},
    '{1'b1, CfgFrameRate,   17'd255,    ACT_TICK, '0, '0, 1'b0, 1'b0, '0},
    '{1'b1, CfgStartFrame,  17'd0,      ACT_TICK, '0, '0, 1'b0, 1'b0, '0},
    '{1'b1, CfgEndFrame,    17'h1FFFF,  ACT_TICK, '0, '0, 1'b0, 1'b0, '0},
    '{1'b1, CfgLooping,     17'd1,      ACT_TICK, '0, '0, 1'b0, 1'b0, '0},
    '{1'b0, '0, '0, ACT_SCRUB,   16'h0000, 16'hFFFF, 1'b0, 1'b1, '{16'hFFFF, 1'b1, 1'b1}},
    // Wrap past the last frame, a zero advance, then a carry out of the phase
    '{1'b0, '0, '0, ACT_TICK,    16'hFFFF, 16'h0000, 1'b0, 1'b0, '0},
    '{1'b0, '0, '0, ACT_TICK,    16'h0000, 16'h0000, 1'b0, 1'b0, '0},
    '{1'b0, '0, '0, ACT_TICK,    16'h0001, 16'h0000, 1'b0, 1'b0, '0},
    // One-shot window 100..200
    '{1'b1, CfgStartFrame,  17'd100,    ACT_TICK, '0, '0, 1'b0, 1'b0, '0},
    '{1'b1, CfgEndFrame,    17'd200,    ACT_TICK, '0, '0, 1'b0, 1'b0, '0},
    '{1'b1, CfgLooping,     17'd0,      ACT_TICK, '0, '0, 1'b0, 1'b0, '0},
    '{1'b0, '0, '0, ACT_SCRUB,   16'h0000, 16'h0000, 1'b0, 1'b1, '{16'd100, 1'b1, 1'b1}},
    '{1'b0, '0, '0, ACT_SCRUB,   16'h0000, 16'hFFFF, 1'b0, 1'b1, '{16'd200, 1'b1, 1'b1}},
    // Already at the end: phase consumed, playing drops, frame holds
    '{1'b0, '0, '0, ACT_TICK,    16'hFFFF, 16'h0000, 1'b0, 1'b1, '{16'd200, 1'b0, 1'b0}},
    '{1'b0, '0, '0, ACT_PLAY,    16'h0000, 16'h0000, 1'b1, 1'b0, '0},
    '{1'b0, '0, '0, ACT_SCRUB,   16'h0000, 16'd150,  1'b0, 1'b1, '{16'd150, 1'b1, 1'b1}},
    // Run into the end: stop there and clear playing
    '{1'b0, '0, '0, ACT_TICK,    16'hFFFF, 16'h0000, 1'b0, 1'b1, '{16'd200, 1'b0, 1'b1}},
    // Start beyond end: end clamps up to start, frame 200 now outside the window
    '{1'b1, CfgLooping,     17'd1,      ACT_TICK, '0, '0, 1'b0, 1'b0, '0},
    '{1'b1, CfgStartFrame,  17'd300,    ACT_TICK, '0, '0, 1'b0, 1'b0, '0},
    '{1'b0, '0, '0, ACT_PLAY,    16'h0000, 16'h0000, 1'b1, 1'b0, '0},
    '{1'b0, '0, '0, ACT_TICK,    16'hFFFF, 16'h0000, 1'b0, 1'b0, '0},
    // Zero total acts as one frame; any end with the sign bit means last frame
    '{1'b1, CfgTotalFrames, 17'd0,      ACT_TICK, '0, '0, 1'b0, 1'b0, '0},
    '{1'b1, CfgEndFrame,    17'h10005,  ACT_TICK, '0, '0, 1'b0, 1'b0, '0},
    '{1'b0, '0, '0, ACT_SCRUB,   16'h0000, 16'hFFFF, 1'b0, 1'b1, '{16'd0, 1'b1, 1'b1}},
    // Oversized total saturates; start at the top frame
    '{1'b1, CfgTotalFrames, 17'h1FFFF,  ACT_TICK, '0, '0, 1'b0, 1'b0, '0},
    '{1'b1, CfgStartFrame,  17'h0FFFF,  ACT_TICK, '0, '0, 1'b0, 1'b0, '0},
    '{1'b0, '0, '0, ACT_SCRUB,   16'h0000, 16'h0000, 1'b0, 1'b1, '{16'hFFFF, 1'b1, 1'b1}},
    // Rate zero never advances; a write past the register list changes nothing
    '{1'b1, CfgFrameRate,   17'd0,      ACT_TICK, '0, '0, 1'b0, 1'b0, '0},
    '{1'b1, CfgNone,        17'h1FFFF,  ACT_TICK, '0, '0, 1'b0, 1'b0, '0},
    '{1'b0, '0, '0, ACT_TICK,    16'hFFFF, 16'h0000, 1'b0, 1'b1, '{16'hFFFF, 1'b1, 1'b0}},
    '{1'b0, '0, '0, ACT_PLAY,    16'h0000, 16'h0000, 1'b0, 1'b1, '{16'hFFFF, 1'b0, 1'b0}},
    '{1'b0, '0, '0, ACT_RESTART, 16'h0000, 16'h0000, 1'b0, 1'b1, '{16'd0, 1'b0, 1'b1}}
  };

  logic               clk_i      = 1'b0;
  logic               rst_ni     = 1'b0;
  logic               cfg_we_i   = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx_i  = '0;
  logic [CfgW-1:0]    cfg_data_i = '0;

  fsp_in_if  in_if ();
  fsp_out_if out_if ();

  // Shadow copy of the registers, starting from their reset values
  logic [RateW-1:0]  rate_cfg  = 8'd30;
  logic [TotalW-1:0] total_cfg = 17'd1;
  logic [FrameW-1:0] start_cfg = '0;
  logic [EndW-1:0]   end_cfg   = 17'h1FFFF;
  logic              loop_cfg  = 1'b1;

  // Shadow playback state
  logic [FrameW-1:0] frame_q   = '0;
  logic [15:0]       phase_q   = '0;
  logic              playing_q = 1'b0;

  // Results owed by the block, oldest first
  playback_result_t pending_status [$];

  int unsigned mismatches   = 0;
  int unsigned results_seen = 0;
  int unsigned rx_wait      = 0;
  bit          tx_calm      = 1'b0;
  bit          rx_calm      = 1'b0;

  frame_sequence_playback_top i_dut (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_idx_i,
    .cfg_data_i,
    .in_i  (in_if),
    .out_o (out_if)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  task automatic report_mismatch(input string what);
    mismatches++;
    $display("[%0t] MISMATCH %s", $time, what);
  endtask

  // Idle cycles before the next item or result; zero throughout a calm stretch
  function automatic int unsigned pick_gap(input bit calm);
    return calm ? 0 : $urandom_range(0, 14);
  endfunction

  // Effective window: total clamped to 1..cap, start clamped to the last frame,
  // a non-negative end clamped into start..last.
  function automatic void window_bounds(output logic [16:0] lo, output logic [16:0] hi);
    logic [16:0] eff;
    logic [16:0] last;
    eff = (total_cfg == '0) ? 17'd1 : total_cfg;
    if (eff > TotalCap) eff = TotalCap;
    last = eff - 17'd1;
    lo = (17'(start_cfg) > last) ? last : 17'(start_cfg);
    if (end_cfg[EndW-1]) begin
      hi = last;
    end else begin
      hi = end_cfg;
      if (hi < lo) hi = lo;
      if (hi > last) hi = last;
    end
  endfunction

  // Advance the shadow state by one item and return the status it produces
  function automatic playback_result_t playback_step(input fsp_action_e act,
                                                     input logic [15:0] delta,
                                                     input logic [15:0] req,
                                                     input logic pv);
    playback_result_t res;
    logic [15:0] prior;
    logic [23:0] prod;
    logic [24:0] acc;
    logic [8:0]  adv;
    logic [16:0] lo;
    logic [16:0] hi;
    logic [16:0] pos;
    logic [17:0] nxt;
    prior = frame_q;
    res.changed = 1'b0;
    case (act)
      ACT_TICK: begin
        if (playing_q) begin
          prod = delta * rate_cfg;
          acc = 25'(phase_q) + 25'(prod);
          adv = acc[24:16];
          phase_q = acc[15:0];
          if (adv != '0) begin
            window_bounds(lo, hi);
            pos = {1'b0, frame_q};
            if (!loop_cfg && pos >= hi) begin
              playing_q = 1'b0;
            end else begin
              if (pos < lo || pos > hi) pos = lo;
              nxt = 18'(pos) + 18'(adv);
              if (nxt > 18'(hi)) begin
                if (loop_cfg) begin
                  nxt = 18'(lo) + (nxt - 18'(lo)) % (18'(hi) - 18'(lo) + 18'd1);
                end else begin
                  nxt = 18'(hi);
                  playing_q = 1'b0;
                end
              end
              frame_q = nxt[15:0];
              res.changed = (frame_q != prior);
            end
          end
        end
      end
      ACT_SCRUB: begin
        window_bounds(lo, hi);
        pos = {1'b0, req};
        if (pos < lo) pos = lo;
        if (pos > hi) pos = hi;
        frame_q = pos[15:0];
        res.changed = 1'b1;
      end
      ACT_PLAY: begin
        playing_q = pv;
      end
      default: begin
        frame_q = '0;
        phase_q = '0;
        res.changed = 1'b1;
      end
    endcase
    res.frame = frame_q;
    res.playing = playing_q;
    return res;
  endfunction

  // Write one register; the block is idle, so update the shadow copy at once
  task automatic write_setting(input logic [CfgIdxW-1:0] idx, input logic [CfgW-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    case (idx)
      CfgFrameRate:   rate_cfg  = data[RateW-1:0];
      CfgTotalFrames: total_cfg = data[TotalW-1:0];
      CfgStartFrame:  start_cfg = data[FrameW-1:0];
      CfgEndFrame:    end_cfg   = data[EndW-1:0];
      CfgLooping:     loop_cfg  = data[0];
      default: ;
    endcase
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Hold off the sender until every owed result has been transferred
  task automatic settle_all();
    in_if.valid <= 1'b0;
    do @(posedge clk_i); while (pending_status.size() != 0);
  endtask

  // Present one item after a random gap; on its transfer, queue what it owes.
  // Typed rows queue their written-down result but still advance the shadow.
  task automatic send_item(input fsp_action_e act, input logic [15:0] delta,
                           input logic [15:0] req, input logic pv,
                           input logic typed, input playback_result_t known);
    int unsigned gap;
    playback_result_t predicted;
    if ($urandom_range(0, 39) == 0) tx_calm = !tx_calm;
    gap = pick_gap(tx_calm);
    if (gap != 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid           <= 1'b1;
    in_if.action          <= act;
    in_if.elapsed         <= delta;
    in_if.requested_frame <= req;
    in_if.play_value      <= pv;
    do @(posedge clk_i); while (!in_if.ready);
    predicted = playback_step(act, delta, req, pv);
    pending_status.insert(pending_status.size(), typed ? known : predicted);
  endtask

  // Result side: check each transfer against the oldest owed result, then
  // drop ready for a random number of cycles before taking the next one.
  always @(posedge clk_i) begin : take_results
    playback_result_t want;
    if (rst_ni) begin
      if (out_if.valid && out_if.ready) begin
        results_seen++;
        if (pending_status.size() == 0) begin
          report_mismatch($sformatf("result %0d arrived with no item pending", results_seen));
        end else begin
          want = pending_status.pop_front();
          if (out_if.frame_index !== want.frame)
            report_mismatch($sformatf("result %0d frame_index %0d, expected %0d",
                                      results_seen, out_if.frame_index, want.frame));
          if (out_if.is_playing !== want.playing)
            report_mismatch($sformatf("result %0d is_playing %0b, expected %0b",
                                      results_seen, out_if.is_playing, want.playing));
          if (out_if.frame_changed !== want.changed)
            report_mismatch($sformatf("result %0d frame_changed %0b, expected %0b",
                                      results_seen, out_if.frame_changed, want.changed));
        end
        if ($urandom_range(0, 39) == 0) rx_calm = !rx_calm;
        rx_wait = pick_gap(rx_calm);
      end else if (rx_wait != 0) begin
        rx_wait--;
      end
      out_if.ready <= (rx_wait == 0);
    end else begin
      out_if.ready <= 1'b0;
    end
  end

  // Give up when nothing has been transferred or written for too long
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < IdleLimit) begin
      @(posedge clk_i);
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) || cfg_we_i) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("[%0t] watchdog: no transfer for %0d cycles", $time, IdleLimit);
    $display("Simulation FAILED");
    $finish;
  end

  initial begin : stimulus
    int unsigned    sel;
    logic [16:0]    tot_v;
    logic [15:0]    start_v;
    logic [16:0]    end_v;
    logic [7:0]     rate_v;
    fsp_action_e    act;
    logic [15:0]    delta;
    logic [15:0]    req;
    logic           pv;

    // Hold every input at a known value from time zero
    in_if.valid           = 1'b0;
    in_if.action          = ACT_TICK;
    in_if.elapsed         = '0;
    in_if.requested_frame = '0;
    in_if.play_value      = 1'b0;

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed script; register rows wait for the block to go idle first
    foreach (script[r]) begin
      if (script[r].is_cfg) begin
        settle_all();
        write_setting(script[r].reg_idx, script[r].reg_data);
      end else begin
        send_item(script[r].act, script[r].delta, script[r].req, script[r].pv,
                  script[r].typed, script[r].known);
      end
    end

    // Random phases: drain, rewrite every register, then a burst of items
    for (int ph = 0; ph < NumPhases; ph++) begin
      settle_all();

      case (ph)
        0:       tot_v = 17'd65536;
        1:       tot_v = 17'h1FFFF;
        2:       tot_v = 17'd0;
        3:       tot_v = 17'd1;
        4:       tot_v = 17'd2;
        default: tot_v = ($urandom_range(0, 3) == 0) ? 17'($urandom)
                                                     : 17'($urandom_range(2, 400));
      endcase
      rate_v = (ph == 5) ? 8'd0 : (ph % 3 == 0) ? 8'd255 : 8'($urandom_range(1, 255));

      sel = $urandom_range(0, 7);
      case (sel)
        0:       start_v = '0;
        1:       start_v = 16'hFFFF;
        2:       start_v = 16'($urandom);
        default: start_v = 16'($urandom_range(0, tot_v));
      endcase

      sel = $urandom_range(0, 7);
      case (sel)
        0:       end_v = 17'h1FFFF;
        1:       end_v = {1'b1, 16'($urandom)};
        2:       end_v = 17'd65535;
        3:       end_v = '0;
        default: end_v = 17'(start_v) + 17'($urandom_range(0, 300));
      endcase

      // Fill the unused upper data bits with noise; the block must drop them
      write_setting(CfgFrameRate,   {9'($urandom), rate_v});
      write_setting(CfgTotalFrames, tot_v);
      write_setting(CfgStartFrame,  {1'($urandom), start_v});
      write_setting(CfgEndFrame,    end_v);
      write_setting(CfgLooping,     {16'($urandom),
                                     (ph < 4) ? 1'(ph % 2) : 1'($urandom_range(0, 1))});
      if ($urandom_range(0, 3) == 0)
        write_setting(CfgNone + CfgIdxW'($urandom_range(0, 2)), 17'($urandom));

      for (int n = 0; n < PhaseItems; n++) begin
        // Mostly ticks, with enough play commands to keep playback going
        sel = $urandom_range(0, 99);
        if (sel < 55)      act = ACT_TICK;
        else if (sel < 70) act = ACT_SCRUB;
        else if (sel < 90) act = ACT_PLAY;
        else               act = ACT_RESTART;

        sel = $urandom_range(0, 5);
        case (sel)
          0:       delta = 16'($urandom_range(0, 600));
          1:       delta = 16'hFFFF;
          2:       delta = '0;
          default: delta = 16'($urandom);
        endcase
        req = $urandom_range(0, 1) ? 16'($urandom) : 16'($urandom_range(0, 500));
        pv  = ($urandom_range(0, 3) != 0);

        send_item(act, delta, req, pv, 1'b0, '0);

        // Now and then let the block run completely dry mid-phase
        if (n != PhaseItems - 1 && $urandom_range(0, 149) == 0) settle_all();
      end
    end

    settle_all();
    repeat (SettleCycles) @(posedge clk_i);

    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

FILE: files.f
hw/rtl/fsp_pkg.sv
hw/rtl/fsp_in_if.sv
hw/rtl/fsp_out_if.sv
hw/rtl/frame_sequence_playback_top.sv
tb/tb_top.sv
